// ===== rtl/mcsm_pkg.sv =====
// shared types, constants and helpers for the clip sequence mixer
package mcsm_pkg;

    localparam int TRACK_SLOTS_DEF  = 4;
    localparam int SAMPLE_DEPTH_DEF = 16384;
    localparam int CLIP_DEPTH_DEF   = 16;
    localparam int SEQ_STEPS_DEF    = 8;

    localparam int ADDR_W   = 14;
    localparam int SAMPLE_W = 16;
    localparam int CLIPID_W = 4;
    localparam int LEN_W    = 15;
    localparam int VOL_W    = 16;
    localparam int SLOT_W   = 3;
    localparam int CNT_W    = 4;

    localparam logic signed [33:0] PCM_PEAK_HI = 34'sd32767;
    localparam logic signed [33:0] PCM_PEAK_LO = -34'sd32768;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SAMPLE = 3'd1,
        OP_CLIP   = 3'd2,
        OP_STEP   = 3'd3,
        OP_START  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLIP,
        S_READ,
        S_MUL,
        S_ACC,
        S_NEXT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]          op;
        logic [ADDR_W-1:0]   sample_addr;
        logic [SAMPLE_W-1:0] sample_value;
        logic [CLIPID_W-1:0] clip_id;
        logic [LEN_W-1:0]    clip_length;
        logic [VOL_W-1:0]    clip_volume;
        logic                clip_silent;
        logic [SLOT_W-1:0]   step_slot;
        logic [CNT_W-1:0]    sequence_count;
    } t_in_word;

    typedef struct packed {
        logic                frame_valid;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                start_accepted;
    } t_out_word;

    // saturate a wide signed sum to int16
    function automatic logic [15:0] sat16(input logic signed [33:0] v);
        logic [15:0] r;
        if (v > PCM_PEAK_HI) r = 16'h7fff;
        else if (v < PCM_PEAK_LO) r = 16'h8000;
        else r = v[15:0];
        return r;
    endfunction

endpackage

// ===== rtl/mcsm_if.sv =====
// valid/ready channel carrying one word
interface mcsm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mcsm_mac.sv =====
// shared multiply and saturating accumulate unit
module mcsm_mac (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic        i_mul,
    input  logic        i_acc,
    input  logic        i_clr,
    input  logic [15:0] i_sample,
    input  logic [15:0] i_volume,
    output logic [15:0] o_acc
);
    logic signed [32:0] r_prod;
    logic signed [15:0] r_a;
    logic        [15:0] r_b;
    logic signed [15:0] r_acc;
    logic signed [32:0] n_quot;
    logic signed [33:0] n_sum;

    // divide by 4096 truncating toward zero
    always_comb begin
        if (r_prod < 0) n_quot = -((-r_prod) >>> 12);
        else n_quot = r_prod >>> 12;
        n_sum = 34'(r_acc) + 34'(n_quot);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_sample;
            r_b <= i_volume;
        end
        if (i_mul) r_prod <= 33'(r_a) * $signed({1'b0, r_b});
        if (i_clr) r_acc <= '0;
        else if (i_acc) r_acc <= mcsm_pkg::sat16(n_sum);
    end

    assign o_acc = r_acc;
endmodule

// ===== rtl/multitrack_clip_sequence_mixer.sv =====
// top level of the clip sequence mixer
// channel | dir | payload
// i_in    | in  | op, sample_addr, sample_value, clip_id, clip_length, ...
// o_out   | out | frame_valid, left, right, start_accepted
// writes and starts pass straight to the done state; a tick visits each track slot
// in turn and runs clip lookup, read, multiply, accumulate and advance per running track
// the single multiplier and the sample memory read port make the running tracks take turns
// reset clears the track state; memories hold garbage until written
// a result waits in the output register; the next word is taken meanwhile
// and holds in the last step until the register is free
module multitrack_clip_sequence_mixer #(
    parameter int TRACK_SLOTS  = mcsm_pkg::TRACK_SLOTS_DEF,
    parameter int SAMPLE_DEPTH = mcsm_pkg::SAMPLE_DEPTH_DEF,
    parameter int CLIP_DEPTH   = mcsm_pkg::CLIP_DEPTH_DEF,
    parameter int SEQ_STEPS    = mcsm_pkg::SEQ_STEPS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mcsm_if.sink   i_in,
    mcsm_if.source o_out
);
    localparam int TW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int SAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int CW = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
    localparam int QW = (SEQ_STEPS > 1) ? $clog2(SEQ_STEPS) : 1;
    localparam int QCW = $clog2(SEQ_STEPS + 1);

    mcsm_pkg::t_state r_state, n_state;
    mcsm_pkg::t_in_word r_in;
    logic [TW:0] r_trk;

    logic [15:0] r_smem [SAMPLE_DEPTH];
    logic [mcsm_pkg::ADDR_W+mcsm_pkg::LEN_W+mcsm_pkg::VOL_W:0] r_ctab [CLIP_DEPTH];
    logic [mcsm_pkg::CLIPID_W-1:0] r_stage [SEQ_STEPS];
    logic [mcsm_pkg::CLIPID_W-1:0] r_list [TRACK_SLOTS][SEQ_STEPS];
    logic [TRACK_SLOTS-1:0] r_run;
    logic [QCW-1:0] r_step [TRACK_SLOTS];
    logic [QCW-1:0] r_cnt [TRACK_SLOTS];
    logic [mcsm_pkg::LEN_W-1:0] r_pos [TRACK_SLOTS];

    logic [mcsm_pkg::ADDR_W+mcsm_pkg::LEN_W+mcsm_pkg::VOL_W:0] r_clip;
    logic [15:0] r_rd;
    logic r_ovalid;
    mcsm_pkg::t_out_word r_out;

    logic [TW-1:0] w_t;
    logic w_active;
    logic [TW:0] w_free;
    logic [QCW-1:0] w_cnt;
    logic [mcsm_pkg::LEN_W-1:0] w_len;
    logic [15:0] w_acc;
    logic w_load, w_mul, w_acc_en, w_clr;

    assign w_t = r_trk[TW-1:0];
    assign w_active = r_run[w_t] && (r_step[w_t] < r_cnt[w_t]);
    assign w_len = (r_clip[mcsm_pkg::VOL_W+mcsm_pkg::LEN_W:mcsm_pkg::VOL_W+1] == '0)
        ? mcsm_pkg::LEN_W'(1) : r_clip[mcsm_pkg::VOL_W+mcsm_pkg::LEN_W:mcsm_pkg::VOL_W+1];

    always_comb begin
        w_free = (TW+1)'(TRACK_SLOTS);
        for (int k = TRACK_SLOTS - 1; k >= 0; k--)
            if (!r_run[k]) w_free = (TW+1)'(k);
        if (int'(r_in.sequence_count) > SEQ_STEPS) w_cnt = QCW'(SEQ_STEPS);
        else w_cnt = QCW'(r_in.sequence_count);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcsm_pkg::S_IDLE: if (i_in.valid && i_in.ready) begin
                if (i_in.data.op == mcsm_pkg::OP_TICK) n_state = mcsm_pkg::S_CLIP;
                else n_state = mcsm_pkg::S_DONE;
            end
            mcsm_pkg::S_CLIP: begin
                if (r_trk == (TW+1)'(TRACK_SLOTS)) n_state = mcsm_pkg::S_DONE;
                else if (r_run[w_t]) n_state = mcsm_pkg::S_READ;
            end
            mcsm_pkg::S_READ: n_state = mcsm_pkg::S_MUL;
            mcsm_pkg::S_MUL:  n_state = mcsm_pkg::S_ACC;
            mcsm_pkg::S_ACC:  n_state = mcsm_pkg::S_NEXT;
            mcsm_pkg::S_NEXT: n_state = mcsm_pkg::S_CLIP;
            mcsm_pkg::S_DONE: if (!r_ovalid) n_state = mcsm_pkg::S_IDLE;
            default: n_state = mcsm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        w_load = 1'b0;
        w_mul = 1'b0;
        w_acc_en = 1'b0;
        w_clr = 1'b0;
        unique case (r_state)
            mcsm_pkg::S_IDLE: w_clr = 1'b1;
            mcsm_pkg::S_MUL:  w_load = 1'b1;
            mcsm_pkg::S_ACC:  w_mul = 1'b1;
            mcsm_pkg::S_NEXT: w_acc_en = w_active && !r_clip[0];
            default: ;
        endcase
    end

    assign i_in.ready = (r_state == mcsm_pkg::S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data = r_out;

    mcsm_mac u_mac (
        .i_clk(i_clk), .i_load(w_load), .i_mul(w_mul), .i_acc(w_acc_en),
        .i_clr(w_clr), .i_sample(r_rd), .i_volume(r_clip[mcsm_pkg::VOL_W:1]),
        .o_acc(w_acc)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == mcsm_pkg::S_DONE && r_in.op == mcsm_pkg::OP_SAMPLE)
            r_smem[SAW'(r_in.sample_addr)] <= r_in.sample_value;
        if (r_state == mcsm_pkg::S_READ)
            r_rd <= r_smem[SAW'(r_clip[mcsm_pkg::ADDR_W+mcsm_pkg::LEN_W+mcsm_pkg::VOL_W:
                mcsm_pkg::LEN_W+mcsm_pkg::VOL_W+1]) + SAW'(r_pos[w_t])];
        if (r_state == mcsm_pkg::S_DONE && r_in.op == mcsm_pkg::OP_CLIP)
            r_ctab[CW'(r_in.clip_id)] <= {r_in.sample_addr, r_in.clip_length,
                r_in.clip_volume, r_in.clip_silent};
        if (r_state == mcsm_pkg::S_CLIP)
            r_clip <= r_ctab[CW'(r_list[w_t][QW'(r_step[w_t])])];
        if (r_state == mcsm_pkg::S_DONE && r_in.op == mcsm_pkg::OP_STEP)
            r_stage[QW'(r_in.step_slot)] <= r_in.clip_id;
        if (r_state == mcsm_pkg::S_DONE && r_in.op == mcsm_pkg::OP_START && !r_ovalid
            && w_free != (TW+1)'(TRACK_SLOTS))
            for (int s = 0; s < SEQ_STEPS; s++) r_list[w_free[TW-1:0]][s] <= r_stage[s];
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_in <= i_in.data;
        if (!i_rst_n) begin
            r_state <= mcsm_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_trk <= '0;
            r_run <= '0;
            for (int k = 0; k < TRACK_SLOTS; k++) begin
                r_step[k] <= '0;
                r_cnt[k] <= '0;
                r_pos[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            if (r_state == mcsm_pkg::S_IDLE) r_trk <= '0;
            if (r_state == mcsm_pkg::S_CLIP && !r_run[w_t] &&
                r_trk != (TW+1)'(TRACK_SLOTS)) r_trk <= r_trk + 1'b1;
            if (r_state == mcsm_pkg::S_NEXT) begin
                r_trk <= r_trk + 1'b1;
                if (w_active) begin
                    if (r_pos[w_t] + 1'b1 >= w_len) begin
                        r_pos[w_t] <= '0;
                        r_step[w_t] <= r_step[w_t] + 1'b1;
                        if (r_step[w_t] + 1'b1 >= r_cnt[w_t]) r_run[w_t] <= 1'b0;
                    end else begin
                        r_pos[w_t] <= r_pos[w_t] + 1'b1;
                    end
                end else begin
                    r_run[w_t] <= 1'b0;
                end
            end
            if (r_state == mcsm_pkg::S_DONE && !r_ovalid) begin
                r_ovalid <= 1'b1;
                r_out.frame_valid <= (r_in.op == mcsm_pkg::OP_TICK);
                r_out.left <= (r_in.op == mcsm_pkg::OP_TICK) ? w_acc : 16'd0;
                r_out.right <= (r_in.op == mcsm_pkg::OP_TICK) ? w_acc : 16'd0;
                r_out.start_accepted <= (r_in.op == mcsm_pkg::OP_START)
                    && (w_free != (TW+1)'(TRACK_SLOTS));
                if (r_in.op == mcsm_pkg::OP_START && w_free != (TW+1)'(TRACK_SLOTS)) begin
                    r_run[w_free[TW-1:0]] <= 1'b1;
                    r_step[w_free[TW-1:0]] <= '0;
                    r_pos[w_free[TW-1:0]] <= '0;
                    r_cnt[w_free[TW-1:0]] <= w_cnt;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mcsm_pkg::S_IDLE) |-> !i_in.ready) else $error("ready while busy");
    a_out_left_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.left == o_out.data.right)) else $error("left != right");
    a_frame_xor_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.data.frame_valid && o_out.data.start_accepted))
        else $error("frame and start flags both set");
`endif
endmodule
